>>> hdl/ibt_pkg.sv
// Shared constants, types and codes for the interval booking table.
`timescale 1ns / 1ps

package ibt_pkg;

	localparam int MAX_RANGES = 64;
	localparam int TIME_BITS  = 30;
	localparam int CNT_BITS   = $clog2(MAX_RANGES + 1);
	localparam int USED_BITS  = 7;

	typedef logic [TIME_BITS-1:0] time_t;
	typedef logic [CNT_BITS-1:0]  cnt_t;

	typedef enum logic [1:0] {
		ST_BOOKED  = 2'd0,
		ST_OVERLAP = 2'd1,
		ST_FULL    = 2'd2,
		ST_EMPTY   = 2'd3
	} status_t;

	// table update applied by every cell in the same cycle
	typedef enum logic [2:0] {
		OP_NONE,
		OP_JOIN,
		OP_EXT_END,
		OP_EXT_START,
		OP_INSERT
	} op_t;

	typedef enum logic {
		FSM_IDLE,
		FSM_UPD
	} fsm_t;

	typedef struct packed {
		logic  capture;
		op_t   op;
		time_t key_s;
		time_t key_e;
	} cell_ctrl_t;

	typedef struct packed {
		logic ov;
		logic lm;
		logic rm;
	} cell_hit_t;

endpackage

>>> hdl/ibt_req_if.sv
// Request channel: valid/ready handshake carrying one booking range.
`timescale 1ns / 1ps

interface ibt_req_if;
	logic                          valid;
	logic                          ready;
	logic [ibt_pkg::TIME_BITS-1:0] start_time;
	logic [ibt_pkg::TIME_BITS-1:0] end_time;

	modport source (output valid, output start_time, output end_time, input ready);
	modport sink   (input valid, input start_time, input end_time, output ready);
endinterface

>>> hdl/ibt_rsp_if.sv
// Response channel: valid/ready handshake carrying status and table occupancy.
`timescale 1ns / 1ps

interface ibt_rsp_if;
	logic                          valid;
	logic                          ready;
	logic [1:0]                    status;
	logic [ibt_pkg::USED_BITS-1:0] entries_used;

	modport source (output valid, output status, output entries_used, input ready);
	modport sink   (input valid, input status, input entries_used, output ready);
endinterface

>>> hdl/ibt_cell.sv
// One table cell: holds a booked range, compares it to a request, shifts with neighbors.
`timescale 1ns / 1ps

module ibt_cell (
	input  logic                clk,
	input  ibt_pkg::cell_ctrl_t ctrl,
	input  logic                used,
	input  logic                prev_lt,
	input  logic                next_lt,
	input  ibt_pkg::time_t      left_start,
	input  ibt_pkg::time_t      left_end,
	input  ibt_pkg::time_t      right_start,
	input  ibt_pkg::time_t      right_end,
	output ibt_pkg::time_t      rng_start,
	output ibt_pkg::time_t      rng_end,
	output logic                lt,
	output ibt_pkg::cell_hit_t  hit
);
	import ibt_pkg::*;

	time_t start_q;
	time_t end_q;
	time_t start_d;
	time_t end_d;
	logic  lt_q;
	logic  egt_q;
	logic  eeq_q;
	logic  slt_q;
	logic  seq_q;
	logic  is_prev;
	logic  is_p;

	// compare flags, taken when the request is accepted
	always_ff @(posedge clk) begin
		if (ctrl.capture) begin
			lt_q  <= used && (start_q < ctrl.key_s);
			egt_q <= end_q > ctrl.key_s;
			eeq_q <= end_q == ctrl.key_s;
			slt_q <= start_q < ctrl.key_e;
			seq_q <= start_q == ctrl.key_e;
		end
	end

	// is_prev: last entry starting below s; is_p: insertion point
	assign is_prev = lt_q && !next_lt;
	assign is_p    = !lt_q && prev_lt;

	assign lt     = lt_q;
	assign hit.ov = (is_prev && egt_q) || (is_p && used && slt_q);
	assign hit.lm = is_prev && eeq_q;
	assign hit.rm = is_p && used && seq_q;

	always_comb begin
		start_d = start_q;
		end_d   = end_q;
		case (ctrl.op)
			OP_JOIN: begin
				if (is_prev) begin
					end_d = right_end;
				end else if (!lt_q) begin
					start_d = right_start;
					end_d   = right_end;
				end
			end
			OP_EXT_END: begin
				if (is_prev) begin
					end_d = ctrl.key_e;
				end
			end
			OP_EXT_START: begin
				if (is_p) begin
					start_d = ctrl.key_s;
				end
			end
			OP_INSERT: begin
				if (is_p) begin
					start_d = ctrl.key_s;
					end_d   = ctrl.key_e;
				end else if (!lt_q) begin
					start_d = left_start;
					end_d   = left_end;
				end
			end
			default: begin
				start_d = start_q;
				end_d   = end_q;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		start_q <= start_d;
		end_q   <= end_d;
	end

	assign rng_start = start_q;
	assign rng_end   = end_q;

endmodule

>>> hdl/interval_booking_table.sv
// Top level of the interval booking table: cell chain, control and result register.
`timescale 1ns / 1ps
//
// Booking calendar over half-open ranges [start_time, end_time).
// req  : sink channel, one booking request per item (start_time, end_time).
// rsp  : source channel, one result per request (status, entries_used).
//        status: booked, overlap refused, table full refused, empty or reversed.
// The table is a chain of MAX_RANGES cells kept in ascending order. When a
// request is accepted every cell compares its range to the request and
// registers the flags; in the update state the flags are reduced, the decision
// is made and all cells shift or update at once (insert shifts right, a join
// of two neighbors shifts left).
// The result register is loaded at the update edge, when the update fires.
// One request is in flight at a time: the compare/update pair of the cell
// chain completes before the next request is accepted.
// Reset clears the state, the entry count (table empty) and the result valid flag; the
// cell contents need no clearing since only entries below the count are used.
// If the receiver stalls, the result stays in the output register and the
// update of the next request waits until that result is taken.
//
module interval_booking_table (
	input  logic        clk,
	input  logic        arst_n,
	ibt_req_if.sink     req,
	ibt_rsp_if.source   rsp
);
	import ibt_pkg::*;

	fsm_t       state_q;
	fsm_t       state_d;
	cnt_t       count_q;
	cnt_t       count_d;
	time_t      req_s_q;
	time_t      req_e_q;
	logic       empty_q;
	logic       rsp_valid_q;
	status_t    rsp_status_q;
	logic [USED_BITS-1:0] rsp_used_q;

	logic       accept;
	logic       upd_fire;
	op_t        op_c;
	status_t    status_c;
	cell_ctrl_t ctrl;

	time_t      start_w [MAX_RANGES];
	time_t      end_w   [MAX_RANGES];
	logic [MAX_RANGES-1:0] lt_v;
	logic [MAX_RANGES-1:0] used_v;
	logic [MAX_RANGES-1:0] ov_v;
	logic [MAX_RANGES-1:0] lm_v;
	logic [MAX_RANGES-1:0] rm_v;
	cell_hit_t  hit_w   [MAX_RANGES];

	assign req.ready = (state_q == FSM_IDLE);
	assign accept    = req.valid && req.ready;
	assign upd_fire  = (state_q == FSM_UPD) && (!rsp_valid_q || rsp.ready);

	// request held for the update cycle
	always_ff @(posedge clk) begin
		if (accept) begin
			req_s_q <= req.start_time;
			req_e_q <= req.end_time;
			empty_q <= !(req.start_time < req.end_time);
		end
	end

	// cells compare against the live payload at accept, the held one at update
	always_comb begin
		ctrl.capture = accept;
		ctrl.op      = upd_fire ? op_c : OP_NONE;
		ctrl.key_s   = (state_q == FSM_IDLE) ? req.start_time : req_s_q;
		ctrl.key_e   = (state_q == FSM_IDLE) ? req.end_time : req_e_q;
	end

	// cell chain
	for (genvar i = 0; i < MAX_RANGES; i++) begin : g_cell
		assign used_v[i] = cnt_t'(i) < count_q;
		assign ov_v[i]   = hit_w[i].ov;
		assign lm_v[i]   = hit_w[i].lm;
		assign rm_v[i]   = hit_w[i].rm;

		ibt_cell u_cell (
			.clk         (clk),
			.ctrl        (ctrl),
			.used        (used_v[i]),
			.prev_lt     ((i == 0) ? 1'b1 : lt_v[(i == 0) ? 0 : i-1]),
			.next_lt     ((i == MAX_RANGES-1) ? 1'b0 : lt_v[(i == MAX_RANGES-1) ? i : i+1]),
			.left_start  ((i == 0) ? time_t'(0) : start_w[(i == 0) ? 0 : i-1]),
			.left_end    ((i == 0) ? time_t'(0) : end_w[(i == 0) ? 0 : i-1]),
			.right_start (start_w[(i == MAX_RANGES-1) ? i : i+1]),
			.right_end   (end_w[(i == MAX_RANGES-1) ? i : i+1]),
			.rng_start   (start_w[i]),
			.rng_end     (end_w[i]),
			.lt          (lt_v[i]),
			.hit         (hit_w[i])
		);
	end

	// decision from the reduced cell flags: empty first, then overlap, then join/extend, then full, then insert
	always_comb begin
		op_c     = OP_NONE;
		status_c = ST_BOOKED;
		count_d  = count_q;
		if (empty_q) begin
			status_c = ST_EMPTY;
		end else if (|ov_v) begin
			status_c = ST_OVERLAP;
		end else if ((|lm_v) && (|rm_v)) begin
			op_c    = OP_JOIN;
			count_d = count_q - cnt_t'(1);
		end else if (|lm_v) begin
			op_c = OP_EXT_END;
		end else if (|rm_v) begin
			op_c = OP_EXT_START;
		end else if (count_q == cnt_t'(MAX_RANGES)) begin
			status_c = ST_FULL;
		end else begin
			op_c    = OP_INSERT;
			count_d = count_q + cnt_t'(1);
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			FSM_IDLE: begin
				if (accept) begin
					state_d = FSM_UPD;
				end
			end
			FSM_UPD: begin
				if (upd_fire) begin
					state_d = FSM_IDLE;
				end
			end
			default: state_d = FSM_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= FSM_IDLE;
			count_q     <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (upd_fire) begin
				count_q     <= count_d;
				rsp_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (upd_fire) begin
			rsp_status_q <= status_c;
			rsp_used_q   <= USED_BITS'(count_d);
		end
	end

	assign rsp.valid        = rsp_valid_q;
	assign rsp.status       = rsp_status_q;
	assign rsp.entries_used = rsp_used_q;

endmodule
